>>> hdl/grid_ray_caster_core_assert.svh
// Assertion macros for the grid ray caster.
// Used by the checker module; no other dependencies.
`ifndef GRID_RAY_CASTER_CORE_ASSERT_SVH
`define GRID_RAY_CASTER_CORE_ASSERT_SVH
// implication, disabled while reset is held
`define GRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define GRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> hdl/grc_pkg.sv
// Package for the grid ray caster: opcodes, status and shade codes, and constants.
// No dependencies.
package grc_pkg;
	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_WALL = 3'd1;
	localparam logic [2:0] OP_PLAYER = 3'd2;
	localparam logic [2:0] OP_CLEAR = 3'd3;
	localparam logic [2:0] OP_READ = 3'd4;
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_LEFT = 2'd1;
	localparam logic [1:0] ST_BLOCKED = 2'd2;
	localparam logic [1:0] SH_FULL = 2'd0;
	localparam logic [1:0] SH_HALF = 2'd1;
	localparam logic [1:0] SH_CORNER = 2'd2;
	localparam int DIR_FRAC = 14;
	localparam logic [17:0] DIST_MAX = 18'h3FFFF;
endpackage

>>> hdl/grc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module grc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/grid_ray_caster_core.sv
// Grid ray caster top level: wall and visibility bitmaps, DDA walker, divider.
// Depends on grc_pkg and grc_ram.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall  | opcode .. player_y
//  out     | output    | out_valid/out_stall| hit, distance, shade, visible_bit, status
//  cfg     | input     | cfg_we             | cfg_wdata (corner_margin)
//
// Map write / read / unknown: read state, then the result. Cast: the start cell is checked
// first, then each cell step runs two serial divisions, then a step for multiply, map read and
// write back; the divider sets the step time.
// Visibility clear: one entry a cycle over all MAP_CELLS entries, then its result; the sweep
// also runs after reset; no item is taken during it. A result waits in the output
// register under stall while nothing new is taken.
module grid_ray_caster_core #(
	parameter int MAP_WIDTH = 64,
	parameter int MAP_CELLS = 4096,
	parameter int FRAC_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [11:0] cell_index,
	input  logic        wall_bit,
	input  logic [15:0] start_x,
	input  logic [15:0] start_y,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic [5:0]  player_x,
	input  logic [5:0]  player_y,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [17:0] distance,
	output logic [1:0]  shade,
	output logic        visible_bit,
	output logic [1:0]  status
);
	localparam int AW = $clog2(MAP_CELLS);
	localparam int MAP_HEIGHT = MAP_CELLS / MAP_WIDTH;
	localparam int IW = 18;                    // signed cell coordinates
	localparam int FW = FRAC_BITS + 1;         // fraction incl. one
	localparam int NW = FW + grc_pkg::DIR_FRAC; // dividend width
	localparam int RW = NW;                    // quotient width
	localparam logic [FW-1:0] ONE_F = FW'(1) << FRAC_BITS;
	localparam int DSTEPS = NW;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_READ, S_RWAIT, S_INIT, S_DIVX, S_DIVY, S_MUL,
		S_STEP, S_CHECK, S_LOOK, S_DECIDE, S_OUT
	} state_t;
	state_t state_q;

	logic [8:0] margin_q;
	logic [2:0] op_q;
	logic [11:0] cell_q;
	logic player_q;
	logic signed [IW-1:0] ix_q, iy_q;
	logic [5:0] px_q, py_q;
	logic posx_q, posy_q;
	logic [15:0] ax_q, ay_q;
	logic [FW-1:0] dx_q, dy_q;
	logic [17:0] dist_q;
	logic [1:0] shade_q;
	logic [RW-1:0] rx_q, ry_q, quo_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] num_q;
	logic [$clog2(DSTEPS+1)-1:0] cnt_q;
	logic [AW-1:0] clr_q, idx_q;
	logic usex_q;
	logic [RW+16-1:0] prod_q;
	logic r_hit_q, r_vis_q;
	logic [17:0] r_dist_q;
	logic [1:0] r_shade_q, r_status_q;

	// memories
	logic wm_we, sm_we, wm_rd, sm_rd, sm_wd;
	logic [AW-1:0] wm_wa, sm_wa, rd_a;
	grc_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_wall (
		.clk(clk), .we(wm_we), .waddr(wm_wa), .wdata(wall_bit),
		.raddr(rd_a), .rdata(wm_rd));
	grc_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_seen (
		.clk(clk), .we(sm_we), .waddr(sm_wa), .wdata(sm_wd),
		.raddr(rd_a), .rdata(sm_rd));

	logic take;
	assign in_stall = (state_q != S_IDLE);
	assign take = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign hit = r_hit_q;
	assign distance = r_dist_q;
	assign shade = r_shade_q;
	assign visible_bit = r_vis_q;
	assign status = r_status_q;

	// write ports: map writes straight from the input, seen writes from clear sweep
	// or walker
	assign wm_we = take && (opcode == grc_pkg::OP_WRITE) &&
		(32'(cell_index) < 32'(MAP_CELLS));
	assign wm_wa = AW'(cell_index);
	assign sm_we = (state_q == S_CLR) ||
		(state_q == S_DECIDE && !player_q && !wm_rd);
	assign sm_wa = (state_q == S_CLR) ? clr_q : idx_q;
	assign sm_wd = (state_q != S_CLR);
	assign rd_a = (state_q == S_IDLE) ? AW'(cell_index) : idx_q;

	// corner margin rescaled to FRAC_BITS
	logic [FW-1:0] mscaled;
	always_comb begin
		if (FRAC_BITS >= 10) begin
			mscaled = FW'({11'd0, margin_q} << (FRAC_BITS - 10));
		end else begin
			mscaled = FW'(margin_q >> (10 - FRAC_BITS));
		end
	end

	// divider step: restoring, one quotient bit a cycle
	logic [15:0] dvsr;
	logic [NW:0] trial;
	assign dvsr = (state_q == S_DIVX) ? ax_q : ay_q;
	assign trial = {rem_q, num_q[NW-1]} - {{(NW-15){1'b0}}, dvsr};

	// step update combinational pieces
	logic [FW-1:0] other;
	logic [RW-1:0] ratio;
	logic [RW+16-1-grc_pkg::DIR_FRAC:0] dec;
	logic [FW-1:0] newother;
	logic [RW:0] dsum;
	logic corner;
	assign ratio = usex_q ? rx_q : ry_q;
	assign other = usex_q ? dy_q : dx_q;
	assign dec = prod_q[RW+16-1:grc_pkg::DIR_FRAC];
	assign newother = ({{(RW+16-grc_pkg::DIR_FRAC-FW){1'b0}}, other} > dec) ?
		FW'({{(RW+16-grc_pkg::DIR_FRAC-FW){1'b0}}, other} - dec) : '0;
	// full-width sum, so a large ratio still saturates the distance
	assign dsum = (RW+1)'(dist_q) + (RW+1)'(ratio);
	assign corner = (newother < mscaled) || ({1'b0, newother} + {1'b0, mscaled} > {1'b0, ONE_F});

	logic rx_lt;
	assign rx_lt = rx_q < ry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			margin_q <= 9'd51;
			op_q <= grc_pkg::OP_WRITE;
		end else begin
			if (cfg_we) begin
				margin_q <= cfg_wdata;
			end
			case (state_q)
			S_CLR: begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(MAP_CELLS - 1)) begin
					// a clear command reports; the sweep after reset does not
					state_q <= (op_q == grc_pkg::OP_CLEAR) ? S_OUT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (take) begin
					op_q <= opcode;
					cell_q <= cell_index;
					player_q <= (opcode == grc_pkg::OP_PLAYER);
					ix_q <= IW'(start_x >> FRAC_BITS);
					iy_q <= IW'(start_y >> FRAC_BITS);
					px_q <= player_x;
					py_q <= player_y;
					posx_q <= !dir_x[15] && (dir_x != 0);
					posy_q <= !dir_y[15] && (dir_y != 0);
					ax_q <= dir_x[15] ? 16'(-dir_x) : dir_x;
					ay_q <= dir_y[15] ? 16'(-dir_y) : dir_y;
					dx_q <= (!dir_x[15] && dir_x != 0) ?
						ONE_F - FW'(start_x[FRAC_BITS-1:0]) : FW'(start_x[FRAC_BITS-1:0]);
					dy_q <= (!dir_y[15] && dir_y != 0) ?
						ONE_F - FW'(start_y[FRAC_BITS-1:0]) : FW'(start_y[FRAC_BITS-1:0]);
					dist_q <= '0;
					shade_q <= grc_pkg::SH_FULL;
					r_hit_q <= 1'b0;
					r_dist_q <= '0;
					r_shade_q <= grc_pkg::SH_FULL;
					r_vis_q <= 1'b0;
					r_status_q <= grc_pkg::ST_DONE;
					if (opcode == grc_pkg::OP_WALL || opcode == grc_pkg::OP_PLAYER) begin
						state_q <= S_CHECK;
					end else if (opcode == grc_pkg::OP_CLEAR) begin
						clr_q <= '0;
						state_q <= S_CLR;
					end else begin
						state_q <= S_READ;
					end
				end
			end
			S_READ: begin
				if (op_q == grc_pkg::OP_READ && 32'(cell_q) < 32'(MAP_CELLS)) begin
					r_vis_q <= sm_rd;
				end
				state_q <= S_OUT;
			end
			S_INIT: begin
				num_q <= NW'(dx_q) << grc_pkg::DIR_FRAC;
				rem_q <= '0;
				cnt_q <= '0;
				state_q <= S_DIVX;
			end
			S_DIVX, S_DIVY: begin
				num_q <= num_q << 1;
				if (!trial[NW]) begin
					rem_q <= trial[NW-1:0];
					quo_q <= {quo_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[NW-2:0], num_q[NW-1]};
					quo_q <= {quo_q[RW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($bits(cnt_q))'(DSTEPS - 1)) begin
					cnt_q <= '0;
					if (state_q == S_DIVX) begin
						rx_q <= (ax_q == 0) ? RW'(ONE_F) :
							{quo_q[RW-2:0], !trial[NW]};
						num_q <= NW'(dy_q) << grc_pkg::DIR_FRAC;
						rem_q <= '0;
						state_q <= S_DIVY;
					end else begin
						ry_q <= (ay_q == 0) ? RW'(ONE_F) :
							{quo_q[RW-2:0], !trial[NW]};
						state_q <= S_MUL;
					end
				end
			end
			S_MUL: begin
				usex_q <= (ax_q != 0) && (ay_q == 0 || rx_lt);
				prod_q <= ((ax_q != 0) && (ay_q == 0 || rx_lt)) ?
					(RW+16)'(rx_q) * (RW+16)'(ay_q) : (RW+16)'(ry_q) * (RW+16)'(ax_q);
				state_q <= S_STEP;
			end
			S_STEP: begin
				if (usex_q) begin
					ix_q <= posx_q ? ix_q + 1'b1 : ix_q - 1'b1;
					dy_q <= newother;
					dx_q <= ONE_F;
					shade_q <= corner ? grc_pkg::SH_CORNER : grc_pkg::SH_FULL;
				end else begin
					iy_q <= posy_q ? iy_q + 1'b1 : iy_q - 1'b1;
					dx_q <= newother;
					dy_q <= ONE_F;
					shade_q <= corner ? grc_pkg::SH_CORNER : grc_pkg::SH_HALF;
				end
				dist_q <= (dsum > (RW+1)'(grc_pkg::DIST_MAX)) ? grc_pkg::DIST_MAX :
					dsum[17:0];
				state_q <= S_CHECK;
			end
			S_CHECK: begin
				if (ix_q < 0 || ix_q >= IW'(MAP_WIDTH) || iy_q < 0 ||
					iy_q >= IW'(MAP_HEIGHT)) begin
					r_status_q <= grc_pkg::ST_LEFT;
					state_q <= S_OUT;
				end else begin
					idx_q <= AW'(iy_q * IW'(MAP_WIDTH) + ix_q);
					state_q <= S_LOOK;
				end
			end
			S_LOOK: begin
				state_q <= S_DECIDE;   // map read in flight
			end
			S_DECIDE: begin
				if (!player_q) begin
					if (wm_rd) begin
						r_hit_q <= 1'b1;
						r_dist_q <= dist_q;
						r_shade_q <= shade_q;
						state_q <= S_OUT;
					end else begin
						state_q <= S_INIT;
					end
				end else if (wm_rd) begin
					r_status_q <= grc_pkg::ST_BLOCKED;
					state_q <= S_OUT;
				end else if (ix_q == IW'(px_q) && iy_q == IW'(py_q)) begin
					r_hit_q <= 1'b1;
					r_dist_q <= dist_q;
					state_q <= S_OUT;
				end else begin
					state_q <= S_INIT;
				end
			end
			S_OUT: begin
				if (!out_stall) begin
					state_q <= S_IDLE;
				end
			end
			S_RWAIT: begin
				state_q <= S_READ;
			end
			default: begin
				state_q <= S_IDLE;
			end
			endcase
		end
	end
endmodule

>>> hdl/grc_checker.sv
// Port-level checker for the grid ray caster, bound to the top level.
// Depends on grid_ray_caster_core_assert.svh and grc_pkg.
`include "grid_ray_caster_core_assert.svh"
module grc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [17:0] distance,
	input logic [1:0]  status,
	input logic        visible_bit
);
	// a stalled result holds
	`GRC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(distance))
	// no intake while a result waits
	`GRC_ASSERT_IMP(a_one_item, clk, arst_n, out_valid, in_stall)
	// a miss carries zero distance
	`GRC_ASSERT_IMP(a_miss_zero, clk, arst_n, out_valid && !hit, distance == 18'd0)
	// hits report done status
	`GRC_ASSERT_IMP(a_hit_status, clk, arst_n, out_valid && hit, status == grc_pkg::ST_DONE)
	// a visibility read never carries a hit
	`GRC_ASSERT_IMP(a_vis_only, clk, arst_n, out_valid && visible_bit, !hit && status == grc_pkg::ST_DONE)
endmodule

bind grid_ray_caster_core grc_checker u_grc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .distance(distance),
	.status(status), .visible_bit(visible_bit));
